/* src/aat_pkg.sv */
`default_nettype none
package aat_pkg;

  localparam int unsigned SCORE_W = 32;
  localparam int unsigned DIV_BITS = 72;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_LOG_DELTA  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_EPS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACC_RATIO  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHAIN_LEN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT_STEPS = 3'd4;

  localparam logic [15:0] LOG_DELTA_RST  = 16'd6246;
  localparam logic [31:0] STOP_EPS_RST   = 32'd66;
  localparam logic [15:0] ACC_RATIO_RST  = 16'd62259;
  localparam logic [15:0] CHAIN_LEN_RST  = 16'd200;
  localparam logic [15:0] INIT_STEPS_RST = 16'd30;

  localparam logic [31:0] IMPOSSIBLE_CODE = 32'h8000_0000;
  localparam logic [31:0] COST_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] TEMP_START      = 32'd3276800;
  localparam logic [31:0] TEMP_FALLBACK   = 32'd6553600;
  localparam logic [29:0] LN2_Q30         = 30'd744261118;
  localparam logic [46:0] VAR_MAX         = '1;
  localparam logic [16:0] ONE_Q16         = 17'h1_0000;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               accepted;
    logic               impossible;
  } item_t;

  typedef enum logic [5:0] {
    S_IDLE, S_ACC, S_STEP,
    S_DEN0, S_DEN1, S_DEN2,
    S_LNORM, S_LSQ, S_LUPD, S_LDIFF, S_LNQ, S_TDIV, S_TDIV_W,
    S_MU, S_MU_W, S_E2_W, S_MUSQ, S_VAR, S_SQRT,
    S_COOL0, S_COOL1, S_X_W, S_T_W, S_CARRY, S_CARRY1, S_RING,
    S_STOP0, S_STOP1, S_STOP2, S_STOP3, S_STOP4,
    S_PP1, S_PP2, S_PP3, S_PP4, S_CMP, S_OUT
  } back_state_t;

endpackage
`default_nettype wire

/* src/aat_front.sv */
`default_nettype none
module aat_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [31:0]         score,
  input  wire logic                accepted,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output aat_pkg::item_t           push_item
);
  import aat_pkg::*;

  logic  held;
  item_t item;

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.score      <= score;
      item.accepted   <= accepted;
      item.impossible <= (score == IMPOSSIBLE_CODE);
    end
  end

endmodule
`default_nettype wire

/* src/aat_queue.sv */
`default_nettype none
module aat_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire aat_pkg::item_t      push_item,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output aat_pkg::item_t           pop_item
);
  import aat_pkg::*;

  item_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* src/aat_div.sv */
`default_nettype none
module aat_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [aat_pkg::DIV_BITS-1:0] dividend,
  input  wire logic [63:0]                  divisor,
  output logic                              done,
  output logic [aat_pkg::DIV_BITS-1:0]      quotient
);
  import aat_pkg::*;

  logic [63:0]          rem;
  logic [63:0]          dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [64:0]          trial;
  logic                 ge;

  assign trial = {rem, quotient[DIV_BITS-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_CNT_W'(DIV_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (cnt != '0) begin
      rem      <= ge ? 64'(trial - {1'b0, dvs}) : trial[63:0];
      quotient <= {quotient[DIV_BITS-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* src/aat_back.sv */
`default_nettype none
module aat_back #(
  parameter int unsigned MEAN_WINDOW = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pop_valid,
  output logic                                 pop_ready,
  input  wire aat_pkg::item_t                  pop_item,
  input  wire logic                            cfg_valid,
  input  wire logic [aat_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [aat_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [31:0]                          temperature,
  output logic                                 done_res,
  output logic                                 initializing
);
  import aat_pkg::*;

  localparam int unsigned PW = (MEAN_WINDOW > 1) ? $clog2(MEAN_WINDOW) : 1;
  localparam int unsigned FW = $clog2(MEAN_WINDOW + 1);

  back_state_t state, state_next;

  logic [15:0] log_delta;
  logic [31:0] stop_eps;
  logic [15:0] acc_ratio;
  logic [15:0] chain_len;

  logic [31:0]        cur_temp;
  logic [31:0]        prev_temp;
  logic [31:0]        rise_count;
  logic [31:0]        fall_count;
  logic [47:0]        fall_sum;
  logic signed [31:0] prev_score;
  logic [15:0]        init_left;
  logic [15:0]        chain_steps;
  logic signed [63:0] cost_sum;
  logic [63:0]        cost_sq_sum;
  logic [16:0]        cost_count;
  logic signed [31:0] last_cost;
  logic [FW-1:0]      ring_fill;
  logic [PW-1:0]      wr_ptr;
  logic signed [31:0] first_mean;
  logic signed [31:0] newest;
  logic signed [31:0] ring [MEAN_WINDOW];
  logic signed [31:0] ring_rd;

  logic [32:0] mul_a;
  logic [32:0] mul_b;
  logic [65:0] prod;

  logic                  div_start;
  logic [DIV_BITS-1:0]   div_dividend;
  logic [63:0]           div_divisor;
  logic                  div_done;
  logic [DIV_BITS-1:0]   div_q;

  logic [47:0]        den_t0;
  logic [49:0]        den_mag;
  logic [63:0]        lv;
  logic [5:0]         lz;
  logic [31:0]        lm;
  logic [29:0]        lr;
  logic [4:0]         li;
  logic               lsel;
  logic [29:0]        la;
  logic signed [31:0] mu;
  logic [31:0]        mu_mag;
  logic [63:0]        e2;
  logic [63:0]        sv;
  logic [63:0]        sr;
  logic [63:0]        sb;
  logic               diff_neg;
  logic               dt_neg;
  logic [32:0]        dt_mag;
  logic [65:0]        nmag;
  logic [65:0]        dmag;
  logic [65:0]        emul;
  logic [131:0]       acc;
  logic               done_bit;

  logic signed [31:0] sc;
  logic [32:0]        fall_wide;
  logic [48:0]        fsum_add;
  logic [31:0]        c_mag;
  logic signed [31:0] c_val;
  logic [50:0]        den_w;
  logic               den_pos;
  logic [33:0]        sq_t;
  logic [31:0]        lm_new;
  logic [29:0]        lr_new;
  logic signed [30:0] l_diff;
  logic [29:0]        lnq;
  logic [16:0]        steps_inc;
  logic               chain_end;
  logic [63:0]        var_w;
  logic [63:0]        var_c;
  logic [63:0]        sqrt_t;
  logic [33:0]        sig3;
  logic signed [32:0] diff_w;
  logic signed [32:0] dt_w;
  logic [31:0]        fm_mag;
  logic [31:0]        last_mag;
  logic               out_free;

  assign prod = 66'(mul_a) * 66'(mul_b);

  assign sc        = $signed(pop_item.score);
  assign fall_wide = 33'({prev_score[31], prev_score} - {sc[31], sc});
  assign fsum_add  = {1'b0, fall_sum} + 49'(fall_wide[31:0]);
  assign c_mag     = pop_item.impossible ? COST_MAX : (sc[31] ? 32'(-sc) : 32'(sc));
  assign c_val     = pop_item.impossible ? $signed(COST_MAX) : -sc;
  assign den_w     = {3'b0, den_t0} - {2'b0, prod[48:0]};
  assign den_pos   = !den_w[50] && (den_w != '0);
  assign sq_t      = prod[64:31];
  assign lm_new    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
  assign lr_new    = sq_t[32] ? (lr | (30'(1) << li)) : lr;
  assign l_diff    = $signed({1'b0, la}) - $signed({1'b0, lr});
  assign lnq       = prod[59:30];
  assign steps_inc = {1'b0, chain_steps} + 17'd1;
  assign chain_end = (steps_inc >= {1'b0, chain_len});
  assign var_w     = (e2 > 64'(prod[65:16])) ? (e2 - 64'(prod[65:16])) : '0;
  assign var_c     = (var_w > 64'(VAR_MAX)) ? 64'(VAR_MAX) : var_w;
  assign sqrt_t    = sr + sb;
  assign sig3      = {1'b0, sr[31:0], 1'b0} + {2'b0, sr[31:0]};
  assign diff_w    = 33'(ring_rd) - 33'(newest);
  assign dt_w      = $signed({1'b0, prev_temp}) - $signed({1'b0, cur_temp});
  assign fm_mag    = first_mean[31] ? 32'(-first_mean) : 32'(first_mean);
  assign last_mag  = last_cost[31] ? 32'(-last_cost) : 32'(last_cost);
  assign out_free  = !out_valid || out_ready;
  assign pop_ready = (state == S_IDLE);

  aat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_IDLE: begin
        if (pop_valid) begin
          if (init_left != '0) begin
            state_next = pop_item.impossible ? S_STOP0 : S_DEN0;
          end else begin
            state_next = pop_item.accepted ? S_ACC : S_STEP;
          end
        end
      end
      S_ACC:   state_next = S_STEP;
      S_STEP:  state_next = chain_end ? S_MU : S_STOP0;
      S_DEN0:  state_next = S_DEN1;
      S_DEN1:  state_next = S_DEN2;
      S_DEN2:  state_next = den_pos ? S_LNORM : S_STOP0;
      S_LNORM: state_next = lv[63] ? S_LSQ : S_LNORM;
      S_LSQ:   state_next = S_LUPD;
      S_LUPD: begin
        if (li != '0) begin
          state_next = S_LSQ;
        end else begin
          state_next = lsel ? S_LDIFF : S_LNORM;
        end
      end
      S_LDIFF: state_next = (l_diff > 0) ? S_LNQ : S_STOP0;
      S_LNQ:   state_next = (lnq != '0) ? S_TDIV : S_STOP0;
      S_TDIV: begin
        div_start    = 1'b1;
        div_dividend = {fall_sum, 24'b0};
        div_divisor  = prod[63:0];
        state_next   = S_TDIV_W;
      end
      S_TDIV_W: state_next = div_done ? S_STOP0 : S_TDIV_W;
      S_MU: begin
        if (cost_count != '0) begin
          div_start    = 1'b1;
          div_dividend = DIV_BITS'(cost_sum[63] ? 64'(-cost_sum) : 64'(cost_sum));
          div_divisor  = 64'(cost_count);
          state_next   = S_MU_W;
        end else begin
          state_next = S_MUSQ;
        end
      end
      S_MU_W: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DIV_BITS'(cost_sq_sum);
          div_divisor  = 64'(cost_count);
          state_next   = S_E2_W;
        end
      end
      S_E2_W:  state_next = div_done ? S_MUSQ : S_E2_W;
      S_MUSQ:  state_next = S_VAR;
      S_VAR:   state_next = S_SQRT;
      S_SQRT:  state_next = sb[0] ? S_COOL0 : S_SQRT;
      S_COOL0: state_next = (sr == '0) ? S_CARRY : S_COOL1;
      S_COOL1: begin
        div_start    = 1'b1;
        div_dividend = DIV_BITS'(prod[47:0]);
        div_divisor  = 64'(sig3);
        state_next   = S_X_W;
      end
      S_X_W: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DIV_BITS'({cur_temp, 16'b0});
          div_divisor  = div_q[63:0] + 64'(ONE_Q16);
          state_next   = S_T_W;
        end
      end
      S_T_W:    state_next = div_done ? S_CARRY : S_T_W;
      S_CARRY:  state_next = (cost_count != '0) ? S_CARRY1 : S_RING;
      S_CARRY1: state_next = S_RING;
      S_RING:   state_next = S_STOP0;
      S_STOP0:  state_next = (ring_fill < FW'(MEAN_WINDOW)) ? S_OUT : S_STOP1;
      S_STOP1:  state_next = S_STOP2;
      S_STOP2:  state_next = S_STOP3;
      S_STOP3: begin
        if (prod == '0 || nmag == '0 ||
            (diff_neg != (first_mean[31] != dt_neg))) begin
          state_next = S_OUT;
        end else begin
          state_next = S_STOP4;
        end
      end
      S_STOP4: state_next = S_PP1;
      S_PP1:   state_next = S_PP2;
      S_PP2:   state_next = S_PP3;
      S_PP3:   state_next = S_PP4;
      S_PP4:   state_next = S_CMP;
      S_CMP:   state_next = S_OUT;
      S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log_delta   <= LOG_DELTA_RST;
      stop_eps    <= STOP_EPS_RST;
      acc_ratio   <= ACC_RATIO_RST;
      chain_len   <= CHAIN_LEN_RST;
      cur_temp    <= TEMP_START;
      prev_temp   <= '0;
      rise_count  <= '0;
      fall_count  <= '0;
      fall_sum    <= '0;
      prev_score  <= $signed(IMPOSSIBLE_CODE);
      init_left   <= INIT_STEPS_RST;
      chain_steps <= '0;
      cost_sum    <= '0;
      cost_sq_sum <= '0;
      cost_count  <= '0;
      last_cost   <= '0;
      ring_fill   <= '0;
      wr_ptr      <= '0;
      first_mean  <= '0;
      out_valid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            if (init_left != '0) begin
              if (!pop_item.impossible) begin
                if (sc > prev_score) begin
                  if (rise_count != '1) rise_count <= rise_count + 1'b1;
                end else begin
                  if (fall_count != '1) fall_count <= fall_count + 1'b1;
                  fall_sum <= fsum_add[48] ? '1 : fsum_add[47:0];
                end
                prev_score <= sc;
              end
            end else if (pop_item.accepted) begin
              last_cost  <= c_val;
              cost_sum   <= cost_sum + 64'(c_val);
              cost_count <= cost_count + 1'b1;
            end
          end
        end
        S_ACC:  cost_sq_sum <= cost_sq_sum + 64'(prod[65:16]);
        S_STEP: if (!chain_end) chain_steps <= steps_inc[15:0];
        S_DEN2: if (!den_pos) cur_temp <= TEMP_FALLBACK;
        S_LNQ: begin
          if (lnq == '0) begin
            cur_temp  <= '1;
            init_left <= init_left - 1'b1;
          end
        end
        S_LDIFF: begin
          if (!(l_diff > 0)) begin
            cur_temp  <= '1;
            init_left <= init_left - 1'b1;
          end
        end
        S_TDIV_W: begin
          if (div_done) begin
            cur_temp  <= (div_q[DIV_BITS-1:32] != '0) ? '1 : div_q[31:0];
            init_left <= init_left - 1'b1;
          end
        end
        S_COOL0: begin
          prev_temp <= cur_temp;
          if (sr == '0) cur_temp <= '0;
        end
        S_T_W: begin
          if (div_done) begin
            cur_temp <= (div_q[DIV_BITS-1:32] != '0) ? '1 : div_q[31:0];
          end
        end
        S_CARRY: begin
          if (cost_count == '0) begin
            cost_sum    <= '0;
            cost_sq_sum <= '0;
          end
        end
        S_CARRY1: begin
          cost_sum    <= 64'(last_cost);
          cost_sq_sum <= 64'(prod[65:16]);
          cost_count  <= 17'd1;
        end
        S_RING: begin
          if (ring_fill == '0) first_mean <= mu;
          wr_ptr <= (wr_ptr == PW'(MEAN_WINDOW - 1)) ? '0 : wr_ptr + 1'b1;
          if (ring_fill < FW'(MEAN_WINDOW)) ring_fill <= ring_fill + 1'b1;
          chain_steps <= '0;
        end
        default: ;
      endcase

      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          CFG_LOG_DELTA:  log_delta <= cfg_data[15:0];
          CFG_STOP_EPS:   stop_eps  <= cfg_data;
          CFG_ACC_RATIO:  acc_ratio <= cfg_data[15:0];
          CFG_CHAIN_LEN:  chain_len <= cfg_data[15:0];
          CFG_INIT_STEPS: init_left <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mul_a <= 33'(c_mag);
        mul_b <= 33'(c_mag);
      end
      S_DEN0: begin
        mul_a <= 33'(fall_count);
        mul_b <= 33'(acc_ratio);
      end
      S_DEN1: begin
        den_t0 <= prod[47:0];
        mul_a  <= 33'(rise_count);
        mul_b  <= 33'(ONE_Q16 - 17'(acc_ratio));
      end
      S_DEN2: begin
        den_mag <= den_w[49:0];
        lv      <= {16'b0, fall_count, 16'b0};
        lz      <= '0;
        lsel    <= 1'b0;
      end
      S_LNORM: begin
        if (lv[63]) begin
          lm <= lv[63:32];
          lr <= {6'(6'd63 - lz), 24'b0};
          li <= 5'd23;
        end else if (lv[63:56] == '0) begin
          lv <= {lv[55:0], 8'b0};
          lz <= lz + 6'd8;
        end else begin
          lv <= {lv[62:0], 1'b0};
          lz <= lz + 6'd1;
        end
      end
      S_LSQ: begin
        mul_a <= 33'(lm);
        mul_b <= 33'(lm);
      end
      S_LUPD: begin
        lm <= lm_new;
        lr <= lr_new;
        li <= li - 1'b1;
        if (li == '0 && !lsel) begin
          la   <= lr_new;
          lsel <= 1'b1;
          lv   <= 64'(den_mag);
          lz   <= '0;
        end
      end
      S_LDIFF: begin
        mul_a <= 33'(l_diff);
        mul_b <= 33'(LN2_Q30);
      end
      S_LNQ: begin
        mul_a <= 33'(fall_count);
        mul_b <= 33'(lnq);
      end
      S_MU: begin
        mu     <= '0;
        mu_mag <= '0;
        e2     <= '0;
      end
      S_MU_W: begin
        if (div_done) begin
          mu_mag <= div_q[31:0];
          mu     <= cost_sum[63] ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
        end
      end
      S_E2_W: if (div_done) e2 <= div_q[63:0];
      S_MUSQ: begin
        mul_a <= 33'(mu_mag);
        mul_b <= 33'(mu_mag);
      end
      S_VAR: begin
        sv <= {var_c[47:0], 16'b0};
        sr <= '0;
        sb <= 64'h4000_0000_0000_0000;
      end
      S_SQRT: begin
        if (sv >= sqrt_t) begin
          sv <= sv - sqrt_t;
          sr <= (sr >> 1) + sb;
        end else begin
          sr <= sr >> 1;
        end
        sb <= sb >> 2;
      end
      S_COOL0: begin
        mul_a <= 33'(cur_temp);
        mul_b <= 33'(log_delta);
      end
      S_CARRY: begin
        mul_a <= 33'(last_mag);
        mul_b <= 33'(last_mag);
      end
      S_STOP1: begin
        diff_neg <= diff_w[32];
        dt_neg   <= dt_w[32];
        dt_mag   <= dt_w[32] ? 33'(-dt_w) : 33'(dt_w);
        mul_a    <= 33'(cur_temp);
        mul_b    <= diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
      end
      S_STOP2: begin
        nmag  <= prod;
        mul_a <= 33'(fm_mag);
        mul_b <= dt_mag;
      end
      S_STOP3: begin
        dmag  <= prod;
        mul_a <= 33'(stop_eps);
        mul_b <= 33'(MEAN_WINDOW - 1);
      end
      S_STOP4: begin
        emul  <= prod;
        mul_a <= dmag[32:0];
        mul_b <= prod[32:0];
      end
      S_PP1: begin
        acc   <= 132'(prod);
        mul_a <= dmag[32:0];
        mul_b <= emul[65:33];
      end
      S_PP2: begin
        acc   <= acc + (132'(prod) << 33);
        mul_a <= dmag[65:33];
        mul_b <= emul[32:0];
      end
      S_PP3: begin
        acc   <= acc + (132'(prod) << 33);
        mul_a <= dmag[65:33];
        mul_b <= emul[65:33];
      end
      S_PP4: acc <= acc + (132'(prod) << 66);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_STOP0: done_bit <= 1'b0;
      S_STOP3: begin
        if (prod == '0) begin
          done_bit <= 1'b0;
        end else if (nmag == '0) begin
          done_bit <= (stop_eps != '0);
        end else begin
          done_bit <= (diff_neg != (first_mean[31] != dt_neg));
        end
      end
      S_CMP: done_bit <= (132'({nmag, 16'b0}) < acc);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      temperature  <= cur_temp;
      done_res     <= done_bit;
      initializing <= (init_left != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RING) begin
      ring[wr_ptr] <= mu;
      newest       <= mu;
    end
    ring_rd <= ring[wr_ptr];
  end

endmodule
`default_nettype wire

/* src/adaptive_annealing_temperature.sv */
// adaptive annealing temperature controller, signed Q16.16 scores in, Q16.16 temperature out
// input channel: in_valid/in_ready with score and accepted; one result per input transaction
// output channel: out_valid/out_ready with temperature, done_res and initializing
// config channel: cfg_valid/cfg_ready (always ready), cfg_index selects register 0..4,
//   writes to other indexes are ignored; write only while the block is idle
// a front stage and a two-entry queue take up to three transactions ahead of the back end,
//   which works on one item at a time with a shared 33x33 multiplier and a
//   72-cycle restoring divider
// cycles per item, set by the back end sequence:
//   ordinary chain step or skipped impossible score: 3 to 14 cycles
//   initial adaptation step: up to about 220 cycles (two 24-step squaring log2 runs
//   on the multiplier plus one divide)
//   chain end: up to about 340 cycles (four divides plus a 32-step square root)
// when the receiver stalls the result holds in the output register and the back end
//   waits; the front and queue keep accepting until full
// reset (rst, synchronous) restores register defaults and temperature 50.0; no clearing pass
`default_nettype none
module adaptive_annealing_temperature #(
  parameter int unsigned MEAN_WINDOW = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] score,
  input  wire logic        accepted,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      temperature,
  output logic             done_res,
  output logic             initializing,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import aat_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  assign cfg_ready = 1'b1;

  aat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .score      (score),
    .accepted   (accepted),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item)
  );

  aat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  aat_back #(
    .MEAN_WINDOW (MEAN_WINDOW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (q_valid),
    .pop_ready    (q_ready),
    .pop_item     (q_item),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .temperature  (temperature),
    .done_res     (done_res),
    .initializing (initializing)
  );

endmodule
`default_nettype wire

/* src/aat_checker.sv */
`default_nettype none
module aat_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] temperature,
  input wire logic        done_res,
  input wire logic        initializing,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature) &&
    $stable(done_res) && $stable(initializing))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without a pending transaction");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd5)
    else $error("more transactions in flight than storage");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind adaptive_annealing_temperature aat_checker u_aat_checker (.*);
`default_nettype wire

/* verif/adaptive_annealing_temperature_tb.sv */
`timescale 1ns / 100ps
module adaptive_annealing_temperature_tb;
  import aat_pkg::*;

  localparam int RING_LEN = 16;
  localparam longint MIN_SCORE = -64'sd2147483648;
  localparam logic [63:0] SAT_TEMP = 64'hFFFF_FFFF;
  localparam logic [63:0] FALL_SUM_CAP = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] VAR_CAP = 64'h7FFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] temperature;
    logic        done_res;
    logic        initializing;
  } temp_result_t;

  class temp_scoreboard;
    int unsigned log_delta, stop_eps, acc_ratio, chain_len, init_steps;
    longint cur_temp, prev_temp, rise_cnt, fall_cnt, prev_score, init_left, chain_steps;
    longint cost_sum, cost_cnt, last_cost, first_mean;
    logic [63:0] fall_sum, cost_sq_sum;
    longint mean_ring[RING_LEN];
    int ring_fill, ring_wr;
    int errors;
    temp_result_t expected_q[$];

    function new();
      log_delta = LOG_DELTA_RST; stop_eps = STOP_EPS_RST; acc_ratio = ACC_RATIO_RST;
      chain_len = CHAIN_LEN_RST; init_steps = INIT_STEPS_RST;
      cur_temp = TEMP_START; prev_temp = 0; rise_cnt = 0; fall_cnt = 0; fall_sum = 0;
      prev_score = MIN_SCORE; init_left = init_steps; chain_steps = 0;
      cost_sum = 0; cost_sq_sum = 0; cost_cnt = 0; last_cost = 0;
      ring_fill = 0; ring_wr = 0; first_mean = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_LOG_DELTA: log_delta = val[15:0];
        CFG_STOP_EPS: stop_eps = val;
        CFG_ACC_RATIO: acc_ratio = val[15:0];
        CFG_CHAIN_LEN: chain_len = val[15:0];
        CFG_INIT_STEPS: begin
          init_steps = val[15:0];
          init_left = init_steps;
        end
        default: ;
      endcase
    endfunction

    function logic [63:0] log2_q24(logic [63:0] v);
      int p;
      logic [63:0] m, r;
      if (v == 0) return 0;
      p = 63;
      while (!v[p]) p--;
      m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
      r = 64'(p) << 24;
      for (int i = 23; i >= 0; i--) begin
        m = (m * m) >> 31;
        if (m >= 64'h1_0000_0000) begin
          m = m >> 1;
          r[i] = 1'b1;
        end
      end
      return r;
    endfunction

    function logic [63:0] isqrt64(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] div_shift_sat(logic [63:0] a, logic [63:0] b, int s);
      logic [63:0] ip, rem, q;
      ip = a / b;
      rem = a % b;
      if (ip > (SAT_TEMP >> s)) return SAT_TEMP;
      q = ip;
      for (int i = 0; i < s; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= b) begin
          rem = rem - b;
          q[0] = 1'b1;
        end
      end
      return {32'd0, q[31:0]};
    endfunction

    function logic [63:0] mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function logic stop_test();
      longint oldest, newest, diff, dt;
      logic [63:0] nmag, dmag, eps15;
      logic [127:0] lhs, rhs, dwide;
      if (ring_fill < RING_LEN) return 1'b0;
      oldest = mean_ring[ring_wr % RING_LEN];
      newest = mean_ring[(ring_wr + RING_LEN - 1) % RING_LEN];
      diff = oldest - newest;
      dt = prev_temp - cur_temp;
      nmag = cur_temp * mag(diff);
      dmag = mag(first_mean) * mag(dt);
      if (dmag == 0) return 1'b0;
      if (nmag == 0) return stop_eps > 0;
      if ((diff < 0) != ((first_mean < 0) != (dt < 0))) return 1'b1;
      lhs = {64'd0, nmag} << 16;
      eps15 = {32'd0, stop_eps} * 64'd15;
      rhs = {64'd0, eps15};
      dwide = {64'd0, dmag};
      rhs = rhs * dwide;
      return lhs < rhs;
    endfunction

    function void adapt_initial(longint sc);
      longint den, l;
      logic [63:0] lnq;
      if (sc == MIN_SCORE) return;
      if (sc > prev_score) begin
        if (rise_cnt != SAT_TEMP) rise_cnt++;
      end else begin
        if (fall_cnt != SAT_TEMP) fall_cnt++;
        fall_sum = fall_sum + 64'(prev_score - sc);
        if (fall_sum > FALL_SUM_CAP) fall_sum = FALL_SUM_CAP;
      end
      prev_score = sc;
      den = fall_cnt * longint'(acc_ratio) - rise_cnt * (65536 - longint'(acc_ratio));
      if (den > 0) begin
        l = longint'(log2_q24(fall_cnt << 16)) - longint'(log2_q24(den));
        lnq = (l > 0) ? ((l * longint'(LN2_Q30)) >> 30) : 0;
        cur_temp = (lnq != 0) ? longint'(div_shift_sat(fall_sum, fall_cnt * lnq, 24))
                              : longint'(SAT_TEMP);
        init_left--;
      end else begin
        cur_temp = TEMP_FALLBACK;
      end
    endfunction

    function void end_chain();
      longint mu;
      logic [63:0] e2, musq, vr, sig, x;
      mu = (cost_cnt != 0) ? cost_sum / cost_cnt : 0;
      e2 = (cost_cnt != 0) ? cost_sq_sum / cost_cnt : 0;
      musq = 64'(mu * mu) >> 16;
      vr = (e2 > musq) ? e2 - musq : 0;
      if (vr > VAR_CAP) vr = VAR_CAP;
      sig = isqrt64(vr << 16);
      prev_temp = cur_temp;
      if (sig == 0) begin
        cur_temp = 0;
      end else begin
        x = (cur_temp * log_delta) / (3 * sig);
        cur_temp = div_shift_sat(cur_temp, 65536 + x, 16);
      end
      if (cost_cnt != 0) begin
        cost_sum = last_cost;
        cost_sq_sum = 64'(last_cost * last_cost) >> 16;
        cost_cnt = 1;
      end else begin
        cost_sum = 0;
        cost_sq_sum = 0;
      end
      if (ring_fill == 0) first_mean = mu;
      mean_ring[ring_wr] = mu;
      ring_wr = (ring_wr + 1) % RING_LEN;
      if (ring_fill < RING_LEN) ring_fill++;
      chain_steps = 0;
    endfunction

    function void note_input(logic [31:0] raw, logic acc);
      longint sc, c;
      temp_result_t r;
      sc = longint'(signed'(raw));
      if (init_left > 0) begin
        adapt_initial(sc);
      end else begin
        if (acc) begin
          c = -sc;
          if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
          last_cost = c;
          cost_sum = cost_sum + c;
          cost_sq_sum = cost_sq_sum + (64'(c * c) >> 16);
          cost_cnt++;
        end
        chain_steps++;
        if (chain_steps >= chain_len) end_chain();
      end
      r.temperature = cur_temp[31:0];
      r.done_res = stop_test();
      r.initializing = init_left > 0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got 0x%08h expected 0x%08h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [31:0] temp, logic done, logic init);
      temp_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result temperature", temp, 0);
      end else begin
        e = expected_q.pop_front();
        if (temp !== e.temperature) report_mismatch("temperature", temp, e.temperature);
        if (done !== e.done_res) report_mismatch("done_res", done, e.done_res);
        if (init !== e.initializing) report_mismatch("initializing", init, e.initializing);
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [31:0] score = 0;
  logic accepted = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [31:0] temperature;
  logic done_res;
  logic initializing;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  temp_scoreboard sb;
  int tx_idle = 32, rx_idle = 56;
  int hold_reqs = 0, hold_seen = 0, hold_left = 0;
  longint level = 0;

  adaptive_annealing_temperature dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .score(score), .accepted(accepted),
    .out_valid(out_valid), .out_ready(out_ready), .temperature(temperature),
    .done_res(done_res), .initializing(initializing),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // receiver side, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(temperature, done_res, initializing);
  end

  task send_item(logic [31:0] sc, logic acc);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    score <= sc;
    accepted <= acc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(sc, acc);
  endtask

  task write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task apply_settings(logic [15:0] ld, logic [31:0] eps, logic [15:0] ar,
                      logic [15:0] cl, logic [15:0] is);
    wait_idle();
    write_reg(CFG_LOG_DELTA, {16'd0, ld});
    write_reg(CFG_STOP_EPS, eps);
    write_reg(CFG_ACC_RATIO, {16'd0, ar});
    write_reg(CFG_CHAIN_LEN, {16'd0, cl});
    write_reg(CFG_INIT_STEPS, {16'd0, is});
  endtask

  function logic [31:0] pick_score();
    int r;
    r = $urandom_range(99);
    if (r < 4) return IMPOSSIBLE_CODE;
    if (r < 14) return $urandom;
    if (r < 20) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0001;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    // costs drifting downward with noise
    level = level + $urandom_range(16384);
    if (level > 64'sd1000000000) level = -64'sd1000000000;
    return 32'(level + longint'($urandom_range(1048576)) - 524288);
  endfunction

  task random_items(int n, bit pressure);
    for (int i = 0; i < n; i++) begin
      if (pressure && i == 10) hold_reqs = hold_reqs + 1;
      send_item(pick_score(), $urandom_range(99) < 70);
    end
  endtask

  initial begin
    logic [31:0] dir_scores[12];
    sb = new();
    dir_scores = '{32'h7FFF_FFFF, IMPOSSIBLE_CODE, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h8000_0001, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0001,
                   32'hFFF0_0000, 32'hFF00_0000, 32'h8000_0001, 32'h0000_0001};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // initial phase at reset settings
    foreach (dir_scores[i]) send_item(dir_scores[i], i[0]);
    // acceptance ratio 0 keeps the initial phase going: impossible score, extremes
    apply_settings(16'd6246, 32'd66, 16'd0, 16'd2, 16'd1);
    foreach (dir_scores[i]) send_item(dir_scores[i], i < 8);

    tx_idle = 32; rx_idle = 56;
    apply_settings(16'd6246, 32'd66, 16'd62259, 16'd4, 16'd3);
    random_items(100, 0);
    apply_settings(16'd65535, 32'hFFFF_FFFF, 16'd0, 16'd1, 16'd1);
    random_items(100, 0);
    tx_idle = 56; rx_idle = 32;
    apply_settings(16'd0, 32'd0, 16'd65535, 16'd7, 16'd5);
    random_items(100, 1);
    apply_settings(16'd1000, 32'd500000, 16'd32768, 16'd65535, 16'd0);
    random_items(80, 0);
    tx_idle = 0; rx_idle = 0;
    apply_settings(16'd20000, 32'd1000, 16'd50000, 16'd3, 16'd2);
    random_items(140, 0);
    apply_settings(16'd123, 32'd7, 16'd1, 16'd16, 16'd65535);
    random_items(80, 0);

    wait_idle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
src/aat_pkg.sv
src/aat_front.sv
src/aat_queue.sv
src/aat_div.sv
src/aat_back.sv
src/adaptive_annealing_temperature.sv
src/aat_checker.sv
verif/adaptive_annealing_temperature_tb.sv
